// ===== hw/rtl/voxel_flood_fill_top_defines.svh =====
// assertion macros for the voxel fill block
`ifndef VOXEL_FLOOD_FILL_TOP_DEFINES_SVH
`define VOXEL_FLOOD_FILL_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VFF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFF_ASSERT(lbl, prop, msg)
`define VFF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/vff_pkg.sv =====
`timescale 1ns / 1ps
package vff_pkg;

  localparam int GRID_SIDE_DEF = 32;
  localparam int VOXEL_W       = 26;
  localparam int COLOR_W       = 24;
  localparam int EXT_REG_W     = 6;
  localparam int COUNT_W       = 16;
  localparam logic [2:0] FACE_COUNT = 3'd6;
  localparam logic [2:0] LAST_DIR   = 3'd5;
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_SOLID = 2'd1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_VOLUME  = 2'd2,
    OP_SURFACE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_EXT_X = 2'd0,
    CFG_EXT_Y = 2'd1,
    CFG_EXT_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_NB,
    ST_NB_WAIT,
    ST_BEY_WAIT,
    ST_AP_RD,
    ST_AP_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ok;
    logic at_edge;
  } nbr_stat_t;

endpackage

// ===== hw/rtl/vff_req_if.sv =====
`timescale 1ns / 1ps
interface vff_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  x_coord;
  logic [4:0]  y_coord;
  logic [4:0]  z_coord;
  logic [2:0]  face;
  logic [1:0]  voxel_kind;
  logic [23:0] voxel_color;

  modport source (output valid, opcode, x_coord, y_coord, z_coord, face, voxel_kind,
                  voxel_color, input ready);
  modport sink (input valid, opcode, x_coord, y_coord, z_coord, face, voxel_kind,
                voxel_color, output ready);
endinterface

// ===== hw/rtl/vff_rsp_if.sv =====
`timescale 1ns / 1ps
interface vff_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  read_kind;
  logic [23:0] read_color;
  logic [15:0] filled_count;

  modport source (output valid, read_kind, read_color, filled_count, input ready);
  modport sink (input valid, read_kind, read_color, filled_count, output ready);
endinterface

// ===== hw/rtl/vff_cfg_if.sv =====
`timescale 1ns / 1ps
interface vff_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/voxel_flood_fill_top.sv =====
`timescale 1ns / 1ps
`include "voxel_flood_fill_top_defines.svh"
// Voxel grid with a breadth-first fill engine. After reset the block sweeps every cell
// of the voxel store and the visited map, one cell a cycle, before it takes any
// transaction; configuration writes are taken throughout. A write, any item whose
// coordinate lies outside the extents, or a surface fill with a face above five is
// answered from idle; a read is answered from the read state. A fill runs a sequencer
// around one neighbor unit and voxel, visited and queue memories with one write port,
// one read port and registered reads: a seed step, then per visited cell a pop and a
// check of up to six neighbors (one or two memory reads per check); then the new value
// is written back to each filled cell. No new item is taken while a fill runs.
module voxel_flood_fill_top #(
  parameter int GRID_SIDE = vff_pkg::GRID_SIDE_DEF
) (
  input logic       clk,
  input logic       rst,
  vff_cfg_if.sink   cfg,
  vff_req_if.sink   req,
  vff_rsp_if.source rsp
);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int EW    = $clog2(GRID_SIDE + 1);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int VW    = vff_pkg::VOXEL_W;

  vff_pkg::state_t state, state_next;

  logic [vff_pkg::EXT_REG_W-1:0] ext_x_reg, ext_y_reg, ext_z_reg;
  logic [EW-1:0] ext_x, ext_y, ext_z;

  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic [VW-1:0] base, fill;
  logic          surface, pos;
  logic [1:0]    nax;
  logic [2:0]    dir;
  logic [AW:0]   head, tail, idx;
  logic [AW-1:0] clr_addr;

  logic          rsp_valid, rsp_set;
  logic [1:0]    rsp_kind;
  logic [23:0]   rsp_color;
  logic [15:0]   rsp_count;

  logic [CW-1:0] nb_x, nb_y, nb_z, bv_x, bv_y, bv_z;
  vff_pkg::nbr_stat_t stat;

  logic          v_we, s_we, q_we, s_wdata, s_rd;
  logic [AW-1:0] v_waddr, v_raddr, s_waddr, s_raddr, q_waddr, q_raddr, q_wdata, q_rd;
  logic [VW-1:0] v_wdata, v_rd;

  logic          acc, in_range, pass_nb, need_bey, push, last_dir;
  logic [AW-1:0] req_addr, cur_addr, nb_addr, bv_addr;
  logic [CW-1:0] rx, ry, rz;
  vff_pkg::opcode_t op;

  function automatic logic [EW-1:0] eff_ext(input logic [vff_pkg::EXT_REG_W-1:0] r);
    logic [7:0] w;
    w = 8'(r);
    if (w == 8'd0) begin
      w = 8'd1;
    end else if (w > 8'(GRID_SIDE)) begin
      w = 8'(GRID_SIDE);
    end
    return EW'(w);
  endfunction

  assign ext_x = eff_ext(ext_x_reg);
  assign ext_y = eff_ext(ext_y_reg);
  assign ext_z = eff_ext(ext_z_reg);

  assign cfg.ready = 1'b1;
  assign req.ready = (state == vff_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign op        = vff_pkg::opcode_t'(req.opcode);

  assign rx       = CW'(req.x_coord);
  assign ry       = CW'(req.y_coord);
  assign rz       = CW'(req.z_coord);
  assign in_range = (8'(req.x_coord) < 8'(ext_x)) && (8'(req.y_coord) < 8'(ext_y))
                    && (8'(req.z_coord) < 8'(ext_z));
  assign req_addr = {rz, ry, rx};
  assign cur_addr = {cur_z, cur_y, cur_x};
  assign nb_addr  = {nb_z, nb_y, nb_x};
  assign bv_addr  = {bv_z, bv_y, bv_x};

  assign pass_nb  = !s_rd && (v_rd == base);
  assign need_bey = surface && !stat.at_edge;
  assign last_dir = (dir == vff_pkg::LAST_DIR);
  assign push     = ((state == vff_pkg::ST_NB_WAIT) && pass_nb && !need_bey)
                    || ((state == vff_pkg::ST_BEY_WAIT)
                        && (v_rd[VW-1:VW-2] == vff_pkg::KIND_SOLID));

  // result is raised after an item answered from idle, a read or a fill
  assign rsp_set  = ((state == vff_pkg::ST_IDLE) && acc && (state_next == vff_pkg::ST_IDLE))
                    || (state == vff_pkg::ST_READ) || (state == vff_pkg::ST_DONE);

  vff_nbr #(.GRID_SIDE(GRID_SIDE)) u_nbr (
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
    .ext_x(ext_x), .ext_y(ext_y), .ext_z(ext_z),
    .dir(dir), .surface(surface), .nax(nax), .pos(pos),
    .nb_x(nb_x), .nb_y(nb_y), .nb_z(nb_z),
    .bv_x(bv_x), .bv_y(bv_y), .bv_z(bv_z),
    .stat(stat)
  );

  vff_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vox (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rd)
  );
  vff_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rd)
  );
  vff_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_que (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vff_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = vff_pkg::ST_IDLE;
      end
      vff_pkg::ST_IDLE: begin
        if (acc && in_range) begin
          case (op)
            vff_pkg::OP_READ:    state_next = vff_pkg::ST_READ;
            vff_pkg::OP_VOLUME:  state_next = vff_pkg::ST_SEED;
            vff_pkg::OP_SURFACE: begin
              if (req.face < vff_pkg::FACE_COUNT) state_next = vff_pkg::ST_SEED;
            end
            default:             state_next = vff_pkg::ST_IDLE;
          endcase
        end
      end
      vff_pkg::ST_READ: state_next = vff_pkg::ST_IDLE;
      vff_pkg::ST_SEED: begin
        if (!surface && v_rd[VW-1:VW-2] == vff_pkg::KIND_EMPTY) begin
          state_next = vff_pkg::ST_DONE;
        end else begin
          state_next = vff_pkg::ST_POP;
        end
      end
      vff_pkg::ST_POP: begin
        state_next = (head == tail) ? vff_pkg::ST_AP_RD : vff_pkg::ST_POP_WAIT;
      end
      vff_pkg::ST_POP_WAIT: state_next = vff_pkg::ST_NB;
      vff_pkg::ST_NB: begin
        if (stat.ok) begin
          state_next = vff_pkg::ST_NB_WAIT;
        end else if (last_dir) begin
          state_next = vff_pkg::ST_POP;
        end
      end
      vff_pkg::ST_NB_WAIT: begin
        if (pass_nb && need_bey) begin
          state_next = vff_pkg::ST_BEY_WAIT;
        end else begin
          state_next = last_dir ? vff_pkg::ST_POP : vff_pkg::ST_NB;
        end
      end
      vff_pkg::ST_BEY_WAIT: state_next = last_dir ? vff_pkg::ST_POP : vff_pkg::ST_NB;
      vff_pkg::ST_AP_RD: state_next = vff_pkg::ST_AP_WR;
      vff_pkg::ST_AP_WR: begin
        if (idx + 1'b1 == tail) state_next = vff_pkg::ST_DONE;
        else state_next = vff_pkg::ST_AP_RD;
      end
      vff_pkg::ST_DONE: state_next = vff_pkg::ST_IDLE;
      default: state_next = vff_pkg::ST_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    v_we    = 1'b0;
    v_waddr = clr_addr;
    v_wdata = '0;
    v_raddr = nb_addr;
    s_we    = 1'b0;
    s_waddr = nb_addr;
    s_wdata = 1'b1;
    s_raddr = nb_addr;
    q_we    = push;
    q_waddr = tail[AW-1:0];
    q_wdata = nb_addr;
    q_raddr = head[AW-1:0];
    case (state)
      vff_pkg::ST_CLEAR: begin
        v_we    = 1'b1;
        s_we    = 1'b1;
        s_waddr = clr_addr;
        s_wdata = 1'b0;
      end
      vff_pkg::ST_IDLE: begin
        v_raddr = req_addr;
        v_waddr = req_addr;
        v_wdata = {req.voxel_kind, req.voxel_color};
        v_we    = acc && in_range && (op == vff_pkg::OP_WRITE);
      end
      vff_pkg::ST_SEED: begin
        s_waddr = cur_addr;
        q_waddr = '0;
        q_wdata = cur_addr;
        if (surface || v_rd[VW-1:VW-2] != vff_pkg::KIND_EMPTY) begin
          s_we = 1'b1;
          q_we = 1'b1;
        end
      end
      vff_pkg::ST_NB_WAIT: begin
        v_raddr = bv_addr;
        s_we    = push;
      end
      vff_pkg::ST_BEY_WAIT: begin
        s_we = push;
      end
      vff_pkg::ST_AP_RD: begin
        q_raddr = idx[AW-1:0];
      end
      vff_pkg::ST_AP_WR: begin
        v_we    = 1'b1;
        v_waddr = q_rd;
        v_wdata = fill;
        s_we    = 1'b1;
        s_waddr = q_rd;
        s_wdata = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vff_pkg::ST_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      idx       <= '0;
      dir       <= '0;
      rsp_valid <= 1'b0;
      ext_x_reg <= vff_pkg::EXT_REG_W'(32);
      ext_y_reg <= vff_pkg::EXT_REG_W'(32);
      ext_z_reg <= vff_pkg::EXT_REG_W'(32);
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (vff_pkg::cfg_reg_t'(cfg.index))
          vff_pkg::CFG_EXT_X: ext_x_reg <= cfg.data;
          vff_pkg::CFG_EXT_Y: ext_y_reg <= cfg.data;
          vff_pkg::CFG_EXT_Z: ext_z_reg <= cfg.data;
          default: begin
          end
        endcase
      end
      if (rsp_set) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        vff_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        vff_pkg::ST_IDLE: begin
          if (acc) begin
            cur_x   <= rx;
            cur_y   <= ry;
            cur_z   <= rz;
            fill    <= {req.voxel_kind, req.voxel_color};
            surface <= (op == vff_pkg::OP_SURFACE);
            nax     <= (op == vff_pkg::OP_SURFACE) ? req.face[2:1] : 2'd0;
            pos     <= (op == vff_pkg::OP_SURFACE) ? !req.face[0] : 1'b1;
            rsp_kind  <= '0;
            rsp_color <= '0;
            rsp_count <= '0;
          end
        end
        vff_pkg::ST_READ: begin
          rsp_kind  <= v_rd[VW-1:VW-2];
          rsp_color <= v_rd[vff_pkg::COLOR_W-1:0];
        end
        vff_pkg::ST_SEED: begin
          base <= v_rd;
          if (q_we) tail <= (AW+1)'(1);
        end
        vff_pkg::ST_POP: begin
          if (head != tail) head <= head + 1'b1;
        end
        vff_pkg::ST_POP_WAIT: begin
          cur_x <= q_rd[CW-1:0];
          cur_y <= q_rd[2*CW-1:CW];
          cur_z <= q_rd[AW-1:2*CW];
          dir   <= '0;
        end
        vff_pkg::ST_NB: begin
          if (!stat.ok) dir <= dir + 1'b1;
        end
        vff_pkg::ST_NB_WAIT, vff_pkg::ST_BEY_WAIT: begin
          if (push) tail <= tail + 1'b1;
          if (state_next != vff_pkg::ST_BEY_WAIT) dir <= dir + 1'b1;
        end
        vff_pkg::ST_AP_WR: idx <= idx + 1'b1;
        vff_pkg::ST_DONE: begin
          rsp_count <= (32'(tail) > 32'hFFFF) ? 16'hFFFF : 16'(tail);
          head      <= '0;
          tail      <= '0;
          idx       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.read_kind    = rsp_kind;
  assign rsp.read_color   = rsp_color;
  assign rsp.filled_count = rsp_count;

  `VFF_ASSERT(a_head_le_tail, head <= tail, "queue head passed tail")
  `VFF_ASSERT(a_ready_idle, req.ready |-> state == vff_pkg::ST_IDLE, "ready outside idle")
  `VFF_ASSERT(a_done_rsp, state == vff_pkg::ST_DONE |=> rsp.valid, "fill gave no result")
  `VFF_ASSERT_ALWAYS(a_rst_busy, rst |=> !req.ready, "ready right after reset")
endmodule

// ===== hw/rtl/vff_ram.sv =====
`timescale 1ns / 1ps
module vff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/vff_nbr.sv =====
`timescale 1ns / 1ps
module vff_nbr #(
  parameter int GRID_SIDE = vff_pkg::GRID_SIDE_DEF
) (
  input  logic [$clog2(GRID_SIDE)-1:0]   cur_x,
  input  logic [$clog2(GRID_SIDE)-1:0]   cur_y,
  input  logic [$clog2(GRID_SIDE)-1:0]   cur_z,
  input  logic [$clog2(GRID_SIDE+1)-1:0] ext_x,
  input  logic [$clog2(GRID_SIDE+1)-1:0] ext_y,
  input  logic [$clog2(GRID_SIDE+1)-1:0] ext_z,
  input  logic [2:0]                     dir,
  input  logic                           surface,
  input  logic [1:0]                     nax,
  input  logic                           pos,
  output logic [$clog2(GRID_SIDE)-1:0]   nb_x,
  output logic [$clog2(GRID_SIDE)-1:0]   nb_y,
  output logic [$clog2(GRID_SIDE)-1:0]   nb_z,
  output logic [$clog2(GRID_SIDE)-1:0]   bv_x,
  output logic [$clog2(GRID_SIDE)-1:0]   bv_y,
  output logic [$clog2(GRID_SIDE)-1:0]   bv_z,
  output vff_pkg::nbr_stat_t             stat
);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int EW = $clog2(GRID_SIDE + 1);

  logic [CW-1:0] c  [4];
  logic [CW-1:0] nb [4];
  logic [CW-1:0] bv [4];
  logic [EW-1:0] e  [4];
  logic [1:0]    ax;

  always_comb begin
    c[0] = cur_x;
    c[1] = cur_y;
    c[2] = cur_z;
    c[3] = '0;
    e[0] = ext_x;
    e[1] = ext_y;
    e[2] = ext_z;
    e[3] = '0;
    ax   = dir[2:1];
    nb   = c;
    stat.ok = 1'b1;
    if (surface && ax == nax) begin
      stat.ok = 1'b0;
    end
    // dir lsb picks the step direction along axis ax
    if (dir[0]) begin
      if (EW'(c[ax]) + EW'(1) >= e[ax]) begin
        stat.ok = 1'b0;
      end
      nb[ax] = c[ax] + CW'(1);
    end else begin
      if (c[ax] == '0) begin
        stat.ok = 1'b0;
      end
      nb[ax] = c[ax] - CW'(1);
    end
    if (pos) begin
      stat.at_edge = (EW'(c[nax]) + EW'(1) == e[nax]);
    end else begin
      stat.at_edge = (c[nax] == '0);
    end
    // voxel one step past the neighbor along the face normal
    bv = nb;
    if (pos) begin
      bv[nax] = nb[nax] + CW'(1);
    end else begin
      bv[nax] = nb[nax] - CW'(1);
    end
  end

  assign nb_x = nb[0];
  assign nb_y = nb[1];
  assign nb_z = nb[2];
  assign bv_x = bv[0];
  assign bv_y = bv[1];
  assign bv_z = bv[2];
endmodule
